### rtl/rtah_pkg.sv
// ----------------------------------------------------------------------------
// Relative to absolute humidity package
// Item types and fixed-point constants shared by the converter modules.
// ----------------------------------------------------------------------------
package rtah_pkg;

    // Input item: temperature and relative humidity readings.
    typedef struct packed {
        logic signed [14:0] temperature_centi_c;
        logic        [13:0] rel_humidity_centi_pct;
    } sample_t;

    // Result item: absolute humidity and its status flags.
    typedef struct packed {
        logic [15:0] abs_humidity_fixed;
        logic        saturated;
        logic        apply_valid;
    } result_t;

    // Width of one power series term (Q30, always below one) and of the sum.
    localparam int TERM_W = 30;
    localparam int SUM_W  = 32;

    // 15 * log2(10) in Q24: the 7.5 factor times two, so that the divisor is
    // twice the Tetens denominator in hundredths.
    localparam logic [29:0] LOG2_10_X15  = 30'd835990575;
    // ln(2) in Q30.
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    // One in Q30.
    localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
    // 237.7 degrees in hundredths.
    localparam logic [16:0] ALPHA_OFFSET = 17'd23770;
    // 273 kelvin in hundredths.
    localparam logic [15:0] KELVIN_OFFSET = 16'd27300;
    // Gas constant scaling of the denominator.
    localparam logic [25:0] GAS_SCALE    = 26'd923;
    // Twice the humidity scaling of the numerator.
    localparam logic [28:0] HUM_SCALE2   = 29'd24440;
    // Above this right shift the rounded value is always zero.
    localparam logic signed [9:0] SHIFT_LIMIT = 10'sd37;
    localparam logic [15:0] MAX_CODE     = 16'hFFFF;

endpackage

### rtl/relative_to_absolute_humidity.sv
// ----------------------------------------------------------------------------
// Relative to absolute humidity converter
// Turns a temperature (0.01 degC) and relative humidity (0.01 %) item into
// absolute humidity in g/m3, unsigned fixed point with FRAC_BITS fraction
// bits, using the Tetens saturation pressure and the ideal gas law.
//
// Channels: sample_valid/sample_ready/sample carry input items, and
// result_valid/result_ready/result carry one result item per input item.
// Throughput: one item per cycle while the skid register is empty; every
// stage is a register stage with a valid bit, so the two dividers (16 and 19
// stages) and the eleven series terms (3 stages each) all hold different
// items at once.
// Stall: a one-item skid register sits behind the last stage. When the
// receiver holds result_ready low, the waiting result moves into the skid
// register and the pipeline keeps accepting for that cycle; while the skid
// register is full, the whole pipeline holds and sample_ready is low.
// Reset: rst_n clears all valid bits and the skid register, so nothing is
// shown until new items are accepted.
// ----------------------------------------------------------------------------
module relative_to_absolute_humidity #(
    parameter int FRAC_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  rtah_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output rtah_pkg::result_t result
);

    localparam int TW     = rtah_pkg::TERM_W;
    localparam int SW     = rtah_pkg::SUM_W;
    localparam int NTERMS = 11;

    // Data that rides alongside the power series.
    typedef struct packed {
        logic [7:0]  ip;
        logic [25:0] gas_den;
        logic [28:0] hum_scaled;
        logic        apply_valid;
    } series_side_t;

    typedef struct packed {
        logic [14:0] tc;
        logic [13:0] hum;
    } front_side_t;

    typedef struct packed {
        logic [7:0] ip;
        logic       apply_valid;
    } back_side_t;

    // The whole pipeline advances unless the skid register is occupied.
    logic en;
    logic skid_full_reg;
    rtah_pkg::result_t skid_reg;

    assign en           = !skid_full_reg;
    assign sample_ready = en;

    // ---------------- Stage 1: capture the item ----------------
    logic        s1_valid_reg;
    logic [14:0] s1_tc_reg;
    logic [13:0] s1_hum_reg;

    // Stage 1 logic: |T| * 15 * log2(10) and twice (237.7 + T).
    logic        tc_neg;
    logic [14:0] tc_abs;
    logic [44:0] mag_prod;
    logic [16:0] den_half;
    logic [44:0] dividend1_next;
    logic [16:0] den1_next;

    assign tc_neg         = s1_tc_reg[14];
    assign tc_abs         = tc_neg ? (~s1_tc_reg + 15'd1) : s1_tc_reg;
    assign mag_prod       = 45'(tc_abs) * 45'(rtah_pkg::LOG2_10_X15);
    assign dividend1_next = {mag_prod[43:0], 1'b0};
    assign den_half       = {{2{s1_tc_reg[14]}}, s1_tc_reg} + rtah_pkg::ALPHA_OFFSET;
    assign den1_next      = {den_half[15:0], 1'b0};

    // ---------------- Stage 2: exponent division operands ----------------
    logic        s2_valid_reg;
    logic [44:0] s2_dividend_reg;
    logic [16:0] s2_den_reg;
    front_side_t s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= sample_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tc_reg       <= sample.temperature_centi_c;
            s1_hum_reg      <= sample.rel_humidity_centi_pct;
            s2_dividend_reg <= dividend1_next;
            s2_den_reg      <= den1_next;
            s2_side_reg     <= '{tc: s1_tc_reg, hum: s1_hum_reg};
        end
    end

    // floor(2 * mag / den); rounding of the exponent follows below.
    logic        d1_valid;
    logic [31:0] d1_quot;
    front_side_t d1_side;

    rtah_div_pipe #(
        .DIVIDEND_W (45),
        .DIVISOR_W  (17),
        .QUO_W      (32),
        .SIDE_W     ($bits(front_side_t))
    ) u_exp_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .src_valid    (s2_valid_reg),
        .src_dividend (s2_dividend_reg),
        .src_divisor  (s2_den_reg),
        .src_side     (s2_side_reg),
        .dst_valid    (d1_valid),
        .dst_quotient (d1_quot),
        .dst_side     (d1_side)
    );

    // ---------------- Stage 3: signed exponent, gas terms ----------------
    logic [31:0] q1_inc;
    logic [30:0] ymag;
    logic [31:0] y_val;
    logic [15:0] kelvin;
    logic [25:0] gas_den_next;
    logic [28:0] hum_scaled_next;
    logic        apply_next;

    assign q1_inc          = d1_quot + 32'd1;
    assign ymag            = q1_inc[31:1];
    assign y_val           = d1_side.tc[14] ? (~{1'b0, ymag} + 32'd1) : {1'b0, ymag};
    assign kelvin          = {d1_side.tc[14], d1_side.tc} + rtah_pkg::KELVIN_OFFSET;
    assign gas_den_next    = 26'(kelvin) * rtah_pkg::GAS_SCALE;
    assign hum_scaled_next = 29'(d1_side.hum) * rtah_pkg::HUM_SCALE2;
    assign apply_next      = !d1_side.tc[14] && (d1_side.tc != 15'd0)
                             && (d1_side.hum != 14'd0);

    logic         s3_valid_reg;
    logic [23:0]  s3_frac_reg;
    series_side_t s3_side_reg;

    // ---------------- Stage 4: z = frac * ln2 ----------------
    logic [53:0]  z_prod;
    assign z_prod = 54'(s3_frac_reg) * 54'(rtah_pkg::LN2_Q30);

    logic         s4_valid_reg;
    logic [TW-1:0] s4_z_reg;
    series_side_t s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= d1_valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_frac_reg <= y_val[23:0];
            s3_side_reg <= '{ip: y_val[31:24], gas_den: gas_den_next,
                             hum_scaled: hum_scaled_next, apply_valid: apply_next};
            s4_z_reg    <= z_prod[53:24];
            s4_side_reg <= s3_side_reg;
        end
    end

    // ---------------- Power series for 2^frac ----------------
    // The first two terms are one and z; each later stage adds term_k.
    logic          ser_valid [NTERMS+1];
    logic [TW-1:0] ser_term  [NTERMS+1];
    logic [TW-1:0] ser_z     [NTERMS+1];
    logic [SW-1:0] ser_sum   [NTERMS+1];
    series_side_t  ser_side  [NTERMS+1];

    assign ser_valid[0] = s4_valid_reg;
    assign ser_term[0]  = s4_z_reg;
    assign ser_z[0]     = s4_z_reg;
    assign ser_sum[0]   = rtah_pkg::ONE_Q30 + SW'(s4_z_reg);
    assign ser_side[0]  = s4_side_reg;

    for (genvar i = 0; i < NTERMS; i++) begin : g_term
        rtah_series_term #(
            .TERM_K (i + 2),
            .SIDE_W ($bits(series_side_t))
        ) u_term (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .src_valid (ser_valid[i]),
            .src_term  (ser_term[i]),
            .src_z     (ser_z[i]),
            .src_sum   (ser_sum[i]),
            .src_side  (ser_side[i]),
            .dst_valid (ser_valid[i+1]),
            .dst_term  (ser_term[i+1]),
            .dst_z     (ser_z[i+1]),
            .dst_sum   (ser_sum[i+1]),
            .dst_side  (ser_side[i+1])
        );
    end

    // ---------------- Stage 5: numerator 2 * H * 12220 * 2^frac ----------------
    // The last z and term are not needed; the sum is 2^frac in Q30.
    series_side_t ser_out;
    logic [60:0]  num_prod;

    assign ser_out  = ser_side[NTERMS];
    assign num_prod = 61'(ser_out.hum_scaled) * 61'(ser_sum[NTERMS]);

    logic        s5_valid_reg;
    logic [59:0] s5_num_reg;
    logic [25:0] s5_den_reg;
    back_side_t  s5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= ser_valid[NTERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_num_reg  <= num_prod[59:0];
            s5_den_reg  <= ser_out.gas_den;
            s5_side_reg <= '{ip: ser_out.ip, apply_valid: ser_out.apply_valid};
        end
    end

    // floor(2N / D): one extra quotient bit serves the final rounding.
    logic        d2_valid;
    logic [37:0] d2_quot;
    back_side_t  d2_side;

    rtah_div_pipe #(
        .DIVIDEND_W (60),
        .DIVISOR_W  (26),
        .QUO_W      (38),
        .SIDE_W     ($bits(back_side_t))
    ) u_gas_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .src_valid    (s5_valid_reg),
        .src_dividend (s5_num_reg),
        .src_divisor  (s5_den_reg),
        .src_side     (s5_side_reg),
        .dst_valid    (d2_valid),
        .dst_quotient (d2_quot),
        .dst_side     (d2_side)
    );

    // ---------------- Stage 6: scale by 2^-t, round, saturate ----------------
    // code = round(N / (D * 2^t)) = (floor(2N/D) + 2^t) >> (t + 1).
    logic signed [9:0] shift_raw;
    logic [5:0]        shift_amt;
    logic [38:0]       rounded;
    rtah_pkg::result_t res_next;

    assign shift_raw = 10'sd30 - 10'(FRAC_BITS) - {{2{d2_side.ip[7]}}, d2_side.ip};
    assign shift_amt = shift_raw[9] ? 6'd0 : shift_raw[5:0];
    assign rounded   = (39'(d2_quot) + (39'd1 << shift_amt)) >> (shift_amt + 6'd1);

    always_comb
    begin
        res_next.apply_valid = d2_side.apply_valid;
        if (!shift_raw[9] && (shift_raw > rtah_pkg::SHIFT_LIMIT))
        begin
            // Far below a quarter code: the value rounds to zero.
            res_next.abs_humidity_fixed = 16'd0;
            res_next.saturated          = 1'b0;
        end
        else if (|rounded[38:16])
        begin
            res_next.abs_humidity_fixed = rtah_pkg::MAX_CODE;
            res_next.saturated          = 1'b1;
        end
        else
        begin
            res_next.abs_humidity_fixed = rounded[15:0];
            res_next.saturated          = 1'b0;
        end
    end

    logic              s6_valid_reg;
    rtah_pkg::result_t s6_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_res_reg <= res_next;
        end
    end

    // ---------------- Output skid register ----------------
    // A result that is not taken parks here so the pipeline can move once more.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (result_ready)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (s6_valid_reg && !result_ready)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && s6_valid_reg && !result_ready)
        begin
            skid_reg <= s6_res_reg;
        end
    end

    assign result_valid = skid_full_reg || s6_valid_reg;
    assign result       = skid_full_reg ? skid_reg : s6_res_reg;

endmodule

### rtl/rtah_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Two quotient bits per register stage; side data travels with each item.
// ----------------------------------------------------------------------------
module rtah_div_pipe #(
    parameter int DIVIDEND_W = 45,
    parameter int DIVISOR_W  = 17,
    parameter int QUO_W      = 32,
    parameter int SIDE_W     = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  src_valid,
    input  logic [DIVIDEND_W-1:0] src_dividend,
    input  logic [DIVISOR_W-1:0]  src_divisor,
    input  logic [SIDE_W-1:0]     src_side,
    output logic                  dst_valid,
    output logic [QUO_W-1:0]      dst_quotient,
    output logic [SIDE_W-1:0]     dst_side
);

    localparam int STAGES = QUO_W / 2;
    localparam int HIGH_W = DIVIDEND_W - QUO_W;

    logic                 valid_reg [STAGES];
    logic [DIVISOR_W-1:0] rem_reg   [STAGES];
    logic [QUO_W-1:0]     work_reg  [STAGES];
    logic [DIVISOR_W-1:0] dvs_reg   [STAGES];
    logic [SIDE_W-1:0]    side_reg  [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic                 v_in;
        logic [DIVISOR_W-1:0] rem_in;
        logic [QUO_W-1:0]     work_in;
        logic [DIVISOR_W-1:0] dvs_in;
        logic [SIDE_W-1:0]    side_in;
        logic [DIVISOR_W-1:0] rem_next;
        logic [QUO_W-1:0]     work_next;

        if (s == 0) begin : g_first
            // The high dividend bits are already below the divisor.
            assign v_in    = src_valid;
            assign rem_in  = {{(DIVISOR_W - HIGH_W){1'b0}},
                              src_dividend[DIVIDEND_W-1:QUO_W]};
            assign work_in = src_dividend[QUO_W-1:0];
            assign dvs_in  = src_divisor;
            assign side_in = src_side;
        end else begin : g_next
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign work_in = work_reg[s-1];
            assign dvs_in  = dvs_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        always_comb
        begin
            logic [DIVISOR_W:0] r2;
            logic [DIVISOR_W:0] diff;
            rem_next  = rem_in;
            work_next = work_in;
            for (int j = 0; j < 2; j++)
            begin
                r2   = {rem_next, work_next[QUO_W-1]};
                diff = r2 - {1'b0, dvs_in};
                if (!diff[DIVISOR_W])
                begin
                    rem_next  = diff[DIVISOR_W-1:0];
                    work_next = {work_next[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = r2[DIVISOR_W-1:0];
                    work_next = {work_next[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                work_reg[s] <= work_next;
                dvs_reg[s]  <= dvs_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign dst_valid    = valid_reg[STAGES-1];
    assign dst_quotient = work_reg[STAGES-1];
    assign dst_side     = side_reg[STAGES-1];

endmodule

### rtl/rtah_series_term.sv
// ----------------------------------------------------------------------------
// Power series term stage
// Computes term * z / K with truncation and adds it to the running sum.
// ----------------------------------------------------------------------------
module rtah_series_term #(
    parameter int TERM_K = 2,
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        src_valid,
    input  logic [rtah_pkg::TERM_W-1:0] src_term,
    input  logic [rtah_pkg::TERM_W-1:0] src_z,
    input  logic [rtah_pkg::SUM_W-1:0]  src_sum,
    input  logic [SIDE_W-1:0]           src_side,
    output logic                        dst_valid,
    output logic [rtah_pkg::TERM_W-1:0] dst_term,
    output logic [rtah_pkg::TERM_W-1:0] dst_z,
    output logic [rtah_pkg::SUM_W-1:0]  dst_sum,
    output logic [SIDE_W-1:0]           dst_side
);

    localparam int TW = rtah_pkg::TERM_W;
    localparam int SW = rtah_pkg::SUM_W;
    // Reciprocal floor(2^32 / K); the estimate is at most one below the quotient.
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TERM_K);
    localparam logic [TW-1:0] K_VAL = TW'(TERM_K);

    logic              a_valid_reg, b_valid_reg, c_valid_reg;
    logic [2*TW-1:0]   a_prod_reg;
    logic [TW-1:0]     a_z_reg, b_z_reg, c_z_reg;
    logic [SW-1:0]     a_sum_reg, b_sum_reg, c_sum_reg;
    logic [SIDE_W-1:0] a_side_reg, b_side_reg, c_side_reg;
    logic [TW-1:0]     b_x_reg, b_q0_reg, c_term_reg;

    logic [2*TW-1:0]   a_prod_next;
    logic [TW+32:0]    recip_prod;
    logic [TW-1:0]     b_x_next, b_q0_next;
    logic [TW-1:0]     rem;
    logic [TW-1:0]     c_term_next;
    logic [SW-1:0]     c_sum_next;

    assign a_prod_next = (2*TW)'(src_term) * (2*TW)'(src_z);
    assign b_x_next    = a_prod_reg[2*TW-1:TW];
    assign recip_prod  = (TW+33)'(b_x_next) * (TW+33)'(RECIP);
    assign b_q0_next   = recip_prod[TW+31:32];
    assign rem         = b_x_reg - TW'(b_q0_reg * K_VAL);
    assign c_term_next = b_q0_reg + TW'(rem >= K_VAL);
    assign c_sum_next  = b_sum_reg + SW'(c_term_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= src_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= a_prod_next;
            a_z_reg    <= src_z;
            a_sum_reg  <= src_sum;
            a_side_reg <= src_side;
            b_x_reg    <= b_x_next;
            b_q0_reg   <= b_q0_next;
            b_z_reg    <= a_z_reg;
            b_sum_reg  <= a_sum_reg;
            b_side_reg <= a_side_reg;
            c_term_reg <= c_term_next;
            c_z_reg    <= b_z_reg;
            c_sum_reg  <= c_sum_next;
            c_side_reg <= b_side_reg;
        end
    end

    assign dst_valid = c_valid_reg;
    assign dst_term  = c_term_reg;
    assign dst_z     = c_z_reg;
    assign dst_sum   = c_sum_reg;
    assign dst_side  = c_side_reg;

endmodule

### sim/relative_to_absolute_humidity_tb.sv
// ----------------------------------------------------------------------------
// Relative to absolute humidity converter testbench
// Drives temperature and humidity items through the converter with random
// sender gaps and receiver stalls, predicts each result with an integer
// Tetens model, and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module relative_to_absolute_humidity_tb;

    localparam int FRAC_BITS = 8;
    localparam int LATENCY   = 74;

    logic              clk;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_ready;
    rtah_pkg::sample_t sample;
    logic              result_valid;
    logic              result_ready;
    rtah_pkg::result_t result;

    // Items still to be sent, and the results predicted for items already sent.
    rtah_pkg::sample_t pending_samples[$];
    rtah_pkg::result_t predicted_results[$];
    int      error_count;
    bit      stimulus_done;
    bit      sample_taken;
    int      burst_left;
    int      gap_left;
    int      stall_mode;

    relative_to_absolute_humidity #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample(sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Integer Tetens conversion. The exponent 7.5*T/(237.7+T) is taken in
    // base two (Q24), split into integer and fraction, and 2^fraction comes
    // from a truncated Taylor series in Q30. Division by the gas term is
    // rounded to nearest with a shift that carries the integer exponent.
    function automatic rtah_pkg::result_t humidity_from_sample(rtah_pkg::sample_t s);
        longint          tc;
        longint unsigned hum;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned ymag;
        longint          y;
        longint unsigned yo;
        longint          ip;
        longint unsigned f;
        longint unsigned z;
        longint unsigned term;
        longint unsigned pw;
        longint unsigned n;
        longint unsigned d;
        longint unsigned dd;
        longint          shift;
        longint unsigned code;
        rtah_pkg::result_t r;
        tc   = longint'(s.temperature_centi_c);
        hum  = longint'(s.rel_humidity_centi_pct);
        mag  = longint'(tc < 0 ? -tc : tc) * 15 * 64'd55732705;
        den  = 2 * (23770 + tc);
        ymag = (2 * mag + den) / (2 * den);
        y    = (tc < 0) ? -longint'(ymag) : longint'(ymag);
        yo   = y + (longint'(64) << 24);
        ip   = longint'(yo >> 24) - 64;
        f    = yo & 64'hFF_FFFF;
        z    = (f * 64'd744261118) >> 24;
        term = 64'd1 << 30;
        pw   = term;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * z) >> 30) / k;
            pw   = pw + term;
        end
        n     = hum * 12220 * pw;
        d     = (tc + 27300) * 923;
        shift = 30 - FRAC_BITS - ip;
        if (shift < 0)
            shift = 0;
        if (shift > 37)
            code = 0;
        else
        begin
            dd   = d << shift;
            code = (2 * n + dd) / (2 * dd);
        end
        r.saturated = 1'b0;
        if (code > 65535)
        begin
            code        = 65535;
            r.saturated = 1'b1;
        end
        r.abs_humidity_fixed = code[15:0];
        r.apply_valid        = (tc > 0 && hum > 0);
        return r;
    endfunction

    function automatic rtah_pkg::sample_t make_sample(int t, int h);
        rtah_pkg::sample_t s;
        s.temperature_centi_c    = t[14:0];
        s.rel_humidity_centi_pct = h[13:0];
        return s;
    endfunction

    // The handshake is judged at the rising edge, where the item is taken.
    always @(posedge clk)
    begin
        sample_taken <= sample_valid && sample_ready;
    end

    // Driver: bursts of items with random gaps, changed at the falling edge.
    // Valid stays high with a steady payload until the item is accepted.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sample_taken)
            begin
                predicted_results.push_back(humidity_from_sample(sample));
                void'(pending_samples.pop_front());
            end
            if (!sample_valid || sample_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left     <= gap_left - 1;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample_valid <= 1'b1;
                    sample       <= pending_samples[0];
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
                    end
                end
                else
                    sample_valid <= 1'b0;
            end
            // Receiver stall pattern: long free-running stretches, sparse
            // stalls and heavy stalls, switched at random.
            if ($urandom_range(63) == 0)
                stall_mode <= $urandom_range(2);
            case (stall_mode)
                0: result_ready <= 1'b1;
                1: result_ready <= ($urandom_range(4) != 0);
                default: result_ready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    // Monitor: every accepted result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result item with no prediction waiting");
                error_count++;
            end
            else
            begin
                rtah_pkg::result_t exp_r;
                exp_r = predicted_results.pop_front();
                if (result.abs_humidity_fixed !== exp_r.abs_humidity_fixed)
                begin
                    $error("abs_humidity_fixed: expected %0d, got %0d",
                        exp_r.abs_humidity_fixed, result.abs_humidity_fixed);
                    error_count++;
                end
                if (result.saturated !== exp_r.saturated)
                begin
                    $error("saturated: expected %0b, got %0b",
                        exp_r.saturated, result.saturated);
                    error_count++;
                end
                if (result.apply_valid !== exp_r.apply_valid)
                begin
                    $error("apply_valid: expected %0b, got %0b",
                        exp_r.apply_valid, result.apply_valid);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        sample_valid  = 1'b0;
        sample        = '0;
        result_ready  = 1'b0;
        rst_n         = 1'b0;
        error_count   = 0;
        stimulus_done = 1'b0;
        sample_taken  = 1'b0;
        burst_left    = 0;
        gap_left      = 0;
        stall_mode    = 0;

        // Directed items: range extremes, zero and negative readings (flag
        // low), the whole 15-bit temperature span, saturation at hot and
        // humid, and very cold dry values that round to zero.
        pending_samples.push_back(make_sample(-4000, 0));
        pending_samples.push_back(make_sample(-4000, 10000));
        pending_samples.push_back(make_sample(8500, 10000));
        pending_samples.push_back(make_sample(8500, 0));
        pending_samples.push_back(make_sample(0, 5000));
        pending_samples.push_back(make_sample(1, 1));
        pending_samples.push_back(make_sample(2500, 5000));
        pending_samples.push_back(make_sample(-1, 5000));
        pending_samples.push_back(make_sample(-16384, 1));
        pending_samples.push_back(make_sample(-16384, 16383));
        pending_samples.push_back(make_sample(16383, 16383));
        pending_samples.push_back(make_sample(16383, 1));
        pending_samples.push_back(make_sample(-16384, 0));
        pending_samples.push_back(make_sample(16383, 0));
        pending_samples.push_back(make_sample(-23000, 16383));
        pending_samples.push_back(make_sample(10000, 16383));
        pending_samples.push_back(make_sample(3700, 9999));
        pending_samples.push_back(make_sample(-2000, 8000));
        pending_samples.push_back(make_sample(6000, 12345));

        // Random items: mostly within the sensor range, some over the
        // whole field so that every bit takes both values.
        for (int i = 0; i < 1450; i++)
        begin
            if ($urandom_range(4) != 0)
                pending_samples.push_back(make_sample(
                    $urandom_range(12500) - 4000, $urandom_range(10000)));
            else
                pending_samples.push_back(make_sample(
                    $urandom_range(32767) - 16384, $urandom_range(16383)));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_samples.size() == 0 && !sample_valid);
        wait (predicted_results.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        stimulus_done = 1'b1;
        if (error_count == 0 && predicted_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4000000;
        if (!stimulus_done)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
